[rtl/core/skt_pkg.sv]
// Package for the sorted key table: sizes, operation and status codes,
// controller states and the command and status structs.
// No dependencies.
package skt_pkg;

    localparam int DEPTH       = 64;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int KEY_W       = 37;
    localparam int PAY_W       = 32;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int CAP_W       = 7;
    localparam int ENT_CNT_W   = 7;
    localparam int ENTRY_W     = KEY_W + PAY_W;
    localparam int EXT_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int MIN_CAP     = 2;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;
    localparam int CAP_RESET   = 64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2
    } op_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE = 2'd0,
        ST_FULL = 2'd1,
        ST_MISS = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_READ,
        S_EVAL,
        S_WRNEW,
        S_FINISH
    } state_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_SHIFT_UP,
        WR_NEW_UP,
        WR_NEW_AT,
        WR_SHIFT_DOWN
    } wr_sel_t;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_ZERO,
        PTR_TOP,
        PTR_INC,
        PTR_DEC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef struct packed {
        logic    load_in;
        ptr_op_t ptr_op;
        logic    rd_en;
        wr_sel_t wr_sel;
        cnt_op_t cnt_op;
        logic    set_found;
        logic    res_we;
        status_t res_val;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            empty;
        logic            key_gt;
        logic            key_eq;
        logic            ptr_zero;
        logic            ptr_last;
        logic            found;
        logic            out_busy;
    } stat_t;

endpackage

[rtl/core/sorted_key_table.sv]
// Sorted key table: keeps up to 64 key and payload entries in ascending key
// order in one RAM with registered read, and handles one operation at a time.
// Every entry visited passes through a read state and then a compare and
// shift state. An insert walks down from the top entry until a key is not
// above the new key or the lowest entry is passed, a remove walks the whole
// table, and a search stops at the match or after the last entry. A full
// insert, a remove or search on an empty table, or an unused operation code
// answers without reading any entry.
// The next operation is taken while the previous result still waits in the
// output register. Capacity is an APB register at address 0 (reset 64).
// Depends on skt_pkg, skt_ctrl, skt_dpath and skt_ram.
module sorted_key_table
    import skt_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OP_W-1:0]      s_operation,
    input  logic [KEY_W-1:0]     s_key,
    input  logic [PAY_W-1:0]     s_payload,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [ST_W-1:0]      m_status,
    output logic [PAY_W-1:0]     m_payload_out,
    output logic [ENT_CNT_W-1:0] m_entry_count
);

    logic [CAP_W-1:0] capacity_reg;
    logic             cap_sel;
    cmd_t             cmd;
    stat_t            stat;

    assign pready  = 1'b1;
    assign cap_sel = paddr[APB_AW-1:2] == '0;
    assign prdata  = cap_sel ? APB_DW'(capacity_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_W'(CAP_RESET);
        end else if (psel && penable && pwrite && cap_sel) begin
            capacity_reg <= pwdata[CAP_W-1:0];
        end
    end

    skt_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_ready(m_ready),
        .stat   (stat),
        .cmd    (cmd)
    );

    skt_dpath u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .capacity     (capacity_reg),
        .s_operation  (s_operation),
        .s_key        (s_key),
        .s_payload    (s_payload),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_status     (m_status),
        .m_payload_out(m_payload_out),
        .m_entry_count(m_entry_count)
    );

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("A second transfer was taken while an operation was running.");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= ENT_CNT_W'(DEPTH))
        else $error("The entry count exceeds the table depth.");

    a_zero_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_FULL || m_status == ST_MISS) |-> m_payload_out == '0)
        else $error("A failed operation returned a nonzero payload.");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> cmd.wr_sel == WR_NONE && cmd.cnt_op == CNT_HOLD)
        else $error("The table changed while no operation was running.");

endmodule

[rtl/core/skt_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/skt_ctrl.sv]
// Controller state machine of the sorted key table.
// Depends on skt_pkg; drives the datapath through cmd_t and reads stat_t.
module skt_ctrl
    import skt_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  logic  m_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd           = '0;
        cmd.ptr_op    = PTR_HOLD;
        cmd.wr_sel    = WR_NONE;
        cmd.cnt_op    = CNT_HOLD;
        cmd.res_val   = ST_MISS;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START: begin
                case (op_t'(stat.op))
                    OP_INSERT: begin
                        if (stat.full) begin
                            cmd.res_we  = 1'b1;
                            cmd.res_val = ST_FULL;
                            state_next  = S_FINISH;
                        end else if (stat.empty) begin
                            cmd.ptr_op = PTR_ZERO;
                            state_next = S_WRNEW;
                        end else begin
                            cmd.ptr_op = PTR_TOP;
                            state_next = S_READ;
                        end
                    end
                    OP_REMOVE, OP_SEARCH: begin
                        if (stat.empty) begin
                            cmd.res_we  = 1'b1;
                            cmd.res_val = ST_MISS;
                            state_next  = S_FINISH;
                        end else begin
                            cmd.ptr_op = PTR_ZERO;
                            state_next = S_READ;
                        end
                    end
                    default: begin
                        cmd.res_we  = 1'b1;
                        cmd.res_val = ST_MISS;
                        state_next  = S_FINISH;
                    end
                endcase
            end
            S_READ: begin
                cmd.rd_en  = 1'b1;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                case (op_t'(stat.op))
                    OP_INSERT: begin
                        if (stat.key_gt) begin
                            cmd.wr_sel = WR_SHIFT_UP;
                            if (stat.ptr_zero) begin
                                state_next = S_WRNEW;
                            end else begin
                                cmd.ptr_op = PTR_DEC;
                                state_next = S_READ;
                            end
                        end else begin
                            cmd.wr_sel  = WR_NEW_UP;
                            cmd.cnt_op  = CNT_INC;
                            cmd.res_we  = 1'b1;
                            cmd.res_val = ST_DONE;
                            state_next  = S_FINISH;
                        end
                    end
                    OP_REMOVE: begin
                        if (stat.found) begin
                            cmd.wr_sel = WR_SHIFT_DOWN;
                        end else if (stat.key_eq) begin
                            cmd.set_found = 1'b1;
                        end
                        if (stat.ptr_last) begin
                            cmd.res_we = 1'b1;
                            if (stat.found || stat.key_eq) begin
                                cmd.cnt_op  = CNT_DEC;
                                cmd.res_val = ST_DONE;
                            end else begin
                                cmd.res_val = ST_MISS;
                            end
                            state_next = S_FINISH;
                        end else begin
                            cmd.ptr_op = PTR_INC;
                            state_next = S_READ;
                        end
                    end
                    default: begin
                        if (stat.key_eq) begin
                            cmd.set_found = 1'b1;
                            cmd.res_we    = 1'b1;
                            cmd.res_val   = ST_DONE;
                            state_next    = S_FINISH;
                        end else if (stat.ptr_last) begin
                            cmd.res_we  = 1'b1;
                            cmd.res_val = ST_MISS;
                            state_next  = S_FINISH;
                        end else begin
                            cmd.ptr_op = PTR_INC;
                            state_next = S_READ;
                        end
                    end
                endcase
            end
            S_WRNEW: begin
                cmd.wr_sel  = WR_NEW_AT;
                cmd.cnt_op  = CNT_INC;
                cmd.res_we  = 1'b1;
                cmd.res_val = ST_DONE;
                state_next  = S_FINISH;
            end
            S_FINISH: begin
                if (!stat.out_busy || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

[rtl/core/skt_dpath.sv]
// Datapath of the sorted key table: item registers, entry pointer, count,
// the entry RAM, the key compare and the result register.
// Depends on skt_pkg and skt_ram.
module skt_dpath
    import skt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic [CAP_W-1:0]   capacity,
    input  logic [OP_W-1:0]    s_operation,
    input  logic [KEY_W-1:0]   s_key,
    input  logic [PAY_W-1:0]   s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [ST_W-1:0]    m_status,
    output logic [PAY_W-1:0]   m_payload_out,
    output logic [ENT_CNT_W-1:0] m_entry_count
);

    logic [OP_W-1:0]      op_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [PAY_W-1:0]     pay_reg;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic                 found_reg;
    logic [PAY_W-1:0]     fpay_reg;
    status_t              res_reg;
    logic                 out_valid_reg;
    logic [ST_W-1:0]      out_status_reg;
    logic [PAY_W-1:0]     out_pay_reg;
    logic [ENT_CNT_W-1:0] out_count_reg;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ENTRY_W-1:0]   ram_rdata;
    logic [KEY_W-1:0]     rkey;
    logic [PAY_W-1:0]     rpay;
    logic [EXT_W-1:0]     cap_ext, cap_eff, cnt_ext;

    skt_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re   (cmd.rd_en),
        .raddr(ptr_reg),
        .rdata(ram_rdata)
    );

    assign rkey = ram_rdata[ENTRY_W-1:PAY_W];
    assign rpay = ram_rdata[PAY_W-1:0];

    always_comb begin
        cap_ext = EXT_W'(capacity);
        cnt_ext = EXT_W'(count_reg);
        if (cap_ext < EXT_W'(MIN_CAP)) begin
            cap_eff = EXT_W'(MIN_CAP);
        end else if (cap_ext > EXT_W'(DEPTH)) begin
            cap_eff = EXT_W'(DEPTH);
        end else begin
            cap_eff = cap_ext;
        end
    end

    always_comb begin
        ram_we    = 1'b1;
        ram_waddr = ptr_reg;
        ram_wdata = {key_reg, pay_reg};
        case (cmd.wr_sel)
            WR_SHIFT_UP: begin
                ram_waddr = ptr_reg + IDX_W'(1);
                ram_wdata = ram_rdata;
            end
            WR_NEW_UP: begin
                ram_waddr = ptr_reg + IDX_W'(1);
            end
            WR_NEW_AT: begin
                ram_waddr = ptr_reg;
            end
            WR_SHIFT_DOWN: begin
                ram_waddr = ptr_reg - IDX_W'(1);
                ram_wdata = ram_rdata;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_comb begin
        case (cmd.ptr_op)
            PTR_ZERO: ptr_next = '0;
            PTR_TOP:  ptr_next = IDX_W'(count_reg - CNT_W'(1));
            PTR_INC:  ptr_next = ptr_reg + IDX_W'(1);
            PTR_DEC:  ptr_next = ptr_reg - IDX_W'(1);
            default:  ptr_next = ptr_reg;
        endcase
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CNT_W'(1);
            CNT_DEC: count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        ptr_reg <= ptr_next;
        if (cmd.load_in) begin
            op_reg  <= s_operation;
            key_reg <= s_key;
            pay_reg <= s_payload;
        end
        if (cmd.set_found) begin
            fpay_reg <= rpay;
        end
        if (cmd.res_we) begin
            res_reg <= cmd.res_val;
        end
        if (cmd.load_out) begin
            out_status_reg <= res_reg;
            out_pay_reg    <= found_reg ? fpay_reg : '0;
            out_count_reg  <= ENT_CNT_W'(count_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (cmd.load_in) begin
                found_reg <= 1'b0;
            end else if (cmd.set_found) begin
                found_reg <= 1'b1;
            end
            if (cmd.load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        stat.op       = op_reg;
        stat.full     = cnt_ext >= cap_eff;
        stat.empty    = count_reg == '0;
        stat.key_gt   = rkey > key_reg;
        stat.key_eq   = rkey == key_reg;
        stat.ptr_zero = ptr_reg == '0;
        stat.ptr_last = CNT_W'(ptr_reg) == (count_reg - CNT_W'(1));
        stat.found    = found_reg;
        stat.out_busy = out_valid_reg;
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_payload_out = out_pay_reg;
    assign m_entry_count = out_count_reg;

endmodule
